// File: rtl/chtwa_pkg.sv
// Package for the clustered hash table with aging: beat types, action codes,
// entry layout and controller states. No dependencies.
package chtwa_pkg;

    typedef enum logic [2:0] {
        ACT_PROBE    = 3'd0,
        ACT_STORE    = 3'd1,
        ACT_NEWGEN   = 3'd2,
        ACT_REFRESH  = 3'd3,
        ACT_CLEAR    = 3'd4,
        ACT_FULLNESS = 3'd5,
        ACT_RSVD6    = 3'd6,
        ACT_RSVD7    = 3'd7
    } action_t;

    typedef struct packed {
        logic [2:0]         action;
        logic [63:0]        key;
        logic signed [31:0] value;
        logic [1:0]         entry_type;
        logic signed [15:0] depth;
        logic [15:0]        move;
        logic signed [31:0] static_value;
    } req_t;

    typedef struct packed {
        logic               hit;
        logic signed [31:0] found_value;
        logic [1:0]         found_type;
        logic signed [15:0] found_depth;
        logic [15:0]        found_move;
        logic signed [31:0] found_static_value;
        logic [9:0]         fullness_permille;
    } rsp_t;

    // One stored entry: tag, score, static eval, move, depth, age, type
    typedef struct packed {
        logic [31:0] tag;
        logic [31:0] score;
        logic [31:0] stat;
        logic [15:0] move;
        logic [15:0] depth;
        logic [7:0]  age;
        logic [1:0]  etype;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);
    localparam int CFG_W   = 13;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN,
        ST_WRITE,
        ST_CLEAR,
        ST_FULL,
        ST_DIVIDE,
        ST_DONE
    } state_t;

endpackage

// File: rtl/chtwa_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module chtwa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/chtwa_div.sv
// Restoring divider, one quotient bit per cycle, for the fullness figure.
// No dependencies.
module chtwa_div #(
    parameter int NW = 24,
    parameter int DW = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic          done,
    output logic [NW-1:0] quo
);

    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0] q_reg, q_next;
    logic [DW:0]   r_reg, r_next;
    logic [DW-1:0] d_reg, d_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          run_reg, run_next;
    logic [DW:0]   trial;

    // shift one bit in, subtract when it fits
    always_comb
    begin
        q_next   = q_reg;
        r_next   = r_reg;
        d_next   = d_reg;
        cnt_next = cnt_reg;
        run_next = run_reg;
        trial    = {r_reg[DW-1:0], q_reg[NW-1]};
        done     = 1'b0;
        if (start)
        begin
            q_next   = num;
            r_next   = '0;
            d_next   = den;
            cnt_next = CW'(NW);
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            if (trial >= {1'b0, d_reg})
            begin
                r_next = trial - {1'b0, d_reg};
                q_next = {q_reg[NW-2:0], 1'b1};
            end
            else
            begin
                r_next = trial;
                q_next = {q_reg[NW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                run_next = 1'b0;
                done     = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            run_reg <= run_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    assign quo = q_next;

endmodule

// File: rtl/clustered_hash_table_with_aging.sv
// Top level of the clustered hash table with aging: controller, entry RAM
// and fullness divider. Depends on chtwa_pkg, chtwa_ram and chtwa_div.

// The table lives in one RAM of CLUSTERS*WAYS entries, one read per cycle.
// Probe and refresh read the ways one a cycle, then give the result; store
// reads the ways, then writes. New search bumps the generation, then gives
// the result. Clear writes one entry a cycle. Fullness reads the n sampled
// entries (n up to FULLNESS_SAMPLE*WAYS) and then divides one quotient bit
// a cycle. After reset a clearing pass over all CLUSTERS*WAYS entries runs
// with busy high and gives no result. The result strobe lasts one cycle and
// cannot be held off.
module clustered_hash_table_with_aging #(
    parameter int CLUSTERS        = 4096,
    parameter int WAYS            = 4,
    parameter int FULLNESS_SAMPLE = 250,
    parameter int EXACT_TYPE      = 0
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  chtwa_pkg::req_t               req,
    output logic                          done,
    output chtwa_pkg::rsp_t               rsp,
    input  logic                          cfg_we,
    input  logic [chtwa_pkg::CFG_W-1:0]   cfg_wdata
);

    localparam int SLOTS = CLUSTERS * WAYS;
    localparam int AW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int WW    = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int CIW   = (CLUSTERS > 1) ? $clog2(CLUSTERS) : 1;
    localparam int SMAX  = (FULLNESS_SAMPLE < CLUSTERS) ? FULLNESS_SAMPLE : CLUSTERS;
    localparam int SW    = $clog2(SMAX * WAYS + 1);
    localparam int NW    = SW + 10;
    localparam int WCW   = $clog2(WAYS + 1);
    localparam int ECW   = $clog2(CLUSTERS + 1);

    chtwa_pkg::state_t state_reg, state_next;
    logic [chtwa_pkg::CFG_W-1:0] cc_reg;
    logic [7:0]   gen_reg, gen_next;
    chtwa_pkg::req_t req_reg, req_next;
    logic [AW-1:0] base_reg, base_next;
    logic [AW:0]  addr_reg, addr_next;
    logic [WCW-1:0] way_reg, way_next;
    logic         rvalid_reg, rvalid_next;
    logic [WW-1:0] rway_reg, rway_next;
    logic         found_reg, found_next;
    logic [WW-1:0] fway_reg, fway_next;
    chtwa_pkg::entry_t fent_reg, fent_next;
    logic [WW-1:0] cway_reg, cway_next;
    chtwa_pkg::entry_t cent_reg, cent_next;
    logic [SW-1:0] cnt_reg, cnt_next;
    logic [SW-1:0] slots_reg, slots_next;
    chtwa_pkg::rsp_t rsp_reg, rsp_next;
    logic         done_reg, done_next;

    logic         we;
    logic [AW-1:0] waddr, raddr;
    chtwa_pkg::entry_t wdata, rdata;
    logic         div_start, div_done;
    logic [NW-1:0] div_q;

    logic [ECW-1:0] eff;
    logic [31:0]  low;
    logic [31+ECW:0] prod;
    logic [CIW-1:0] cidx;
    logic         c1, c2, c3, c4, is_last;

    // effective cluster count and cluster index
    always_comb
    begin
        eff = (cc_reg == '0) ? ECW'(1)
            : (32'(cc_reg) > 32'(CLUSTERS)) ? ECW'(CLUSTERS) : ECW'(cc_reg);
        low  = req.key[31:0];
        prod = (32 + ECW)'(low) * (32 + ECW)'(eff);
        cidx = CIW'(prod[31+ECW:32]);
    end

    chtwa_ram #(.WIDTH(chtwa_pkg::ENTRY_W), .DEPTH(SLOTS)) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    chtwa_div #(.NW(NW), .DW(SW)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (NW'(cnt_reg) * NW'(1000)),
        .den   (slots_reg),
        .done  (div_done),
        .quo   (div_q)
    );

    // victim rule against the way now returned
    always_comb
    begin
        c1 = cent_reg.age == gen_reg;
        c2 = rdata.age == gen_reg;
        c3 = rdata.etype == 2'(EXACT_TYPE);
        c4 = $signed(rdata.depth) < $signed(cent_reg.depth);
        is_last = 32'(rway_reg) == 32'(WAYS - 1);
    end

    // sequencer
    always_comb
    begin
        state_next  = state_reg;
        gen_next    = gen_reg;
        req_next    = req_reg;
        base_next   = base_reg;
        addr_next   = addr_reg;
        way_next    = way_reg;
        rvalid_next = 1'b0;
        rway_next   = rway_reg;
        found_next  = found_reg;
        fway_next   = fway_reg;
        fent_next   = fent_reg;
        cway_next   = cway_reg;
        cent_next   = cent_reg;
        cnt_next    = cnt_reg;
        slots_next  = slots_reg;
        rsp_next    = rsp_reg;
        done_next   = 1'b0;
        we          = 1'b0;
        waddr       = addr_reg[AW-1:0];
        wdata       = '0;
        raddr       = addr_reg[AW-1:0];
        div_start   = 1'b0;
        busy        = state_reg != chtwa_pkg::ST_IDLE;

        case (state_reg)
            chtwa_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    req_next = req;
                    rsp_next = '0;
                    case (chtwa_pkg::action_t'(req.action))
                        chtwa_pkg::ACT_PROBE, chtwa_pkg::ACT_STORE,
                        chtwa_pkg::ACT_REFRESH:
                        begin
                            base_next  = AW'(32'(cidx) * WAYS);
                            way_next   = '0;
                            found_next = 1'b0;
                            state_next = chtwa_pkg::ST_SCAN;
                        end
                        chtwa_pkg::ACT_NEWGEN:
                        begin
                            gen_next   = gen_reg + 8'd1;
                            state_next = chtwa_pkg::ST_DONE;
                        end
                        chtwa_pkg::ACT_CLEAR:
                        begin
                            addr_next  = '0;
                            state_next = chtwa_pkg::ST_CLEAR;
                        end
                        chtwa_pkg::ACT_FULLNESS:
                        begin
                            addr_next  = '0;
                            way_next   = '0;
                            cnt_next   = '0;
                            slots_next = SW'(((32'(eff) < SMAX) ? 32'(eff) : SMAX) * WAYS);
                            state_next = chtwa_pkg::ST_FULL;
                        end
                        default:
                        begin
                            state_next = chtwa_pkg::ST_DONE;
                        end
                    endcase
                end
            end

            chtwa_pkg::ST_SCAN:
            begin
                // issue one way a cycle, evaluate the way returned
                if (32'(way_reg) < WAYS)
                begin
                    raddr     = base_reg + AW'(way_reg);
                    rway_next = WW'(way_reg);
                    rvalid_next = 1'b1;
                    way_next  = way_reg + 1'b1;
                end
                if (rvalid_reg)
                begin
                    if (req_reg.action == chtwa_pkg::ACT_STORE)
                    begin
                        if (!found_reg && (rdata.tag == '0 || rdata.tag == req_reg.key[63:32]))
                        begin
                            found_next = 1'b1;
                            fway_next  = rway_reg;
                            fent_next  = rdata;
                        end
                        if (rway_reg == '0)
                        begin
                            cway_next = '0;
                            cent_next = rdata;
                        end
                        else if ((c1 && c4) || (!(c2 || c3) && (c4 || c1)))
                        begin
                            cway_next = rway_reg;
                            cent_next = rdata;
                        end
                    end
                    else if (!found_reg && rdata.tag == req_reg.key[63:32])
                    begin
                        found_next = 1'b1;
                        fway_next  = rway_reg;
                        fent_next  = rdata;
                    end
                    if (is_last)
                    begin
                        if (req_reg.action == chtwa_pkg::ACT_STORE)
                        begin
                            state_next = chtwa_pkg::ST_WRITE;
                        end
                        else
                        begin
                            state_next = chtwa_pkg::ST_DONE;
                        end
                    end
                end
            end

            chtwa_pkg::ST_WRITE:
            begin
                // first empty or matching way wins, else the victim
                waddr = base_reg + AW'(found_reg ? fway_reg : cway_reg);
                we    = 1'b1;
                wdata.tag   = req_reg.key[63:32];
                wdata.score = req_reg.value;
                wdata.stat  = req_reg.static_value;
                wdata.move  = (req_reg.move != '0) ? req_reg.move
                            : (found_reg ? fent_reg.move : cent_reg.move);
                wdata.depth = req_reg.depth;
                wdata.age   = gen_reg;
                wdata.etype = req_reg.entry_type;
                done_next   = 1'b1;
                state_next  = chtwa_pkg::ST_IDLE;
            end

            chtwa_pkg::ST_CLEAR:
            begin
                we        = 1'b1;
                waddr     = addr_reg[AW-1:0];
                wdata     = '0;
                addr_next = addr_reg + 1'b1;
                if (32'(addr_reg) == SLOTS - 1)
                begin
                    // the pass after reset drops back to idle with no beat
                    state_next = (req_reg.action == chtwa_pkg::ACT_CLEAR)
                               ? chtwa_pkg::ST_DONE : chtwa_pkg::ST_IDLE;
                end
            end

            chtwa_pkg::ST_FULL:
            begin
                // sweep the sampled entries and count current ages
                if (32'(addr_reg) < 32'(slots_reg))
                begin
                    raddr       = addr_reg[AW-1:0];
                    rvalid_next = 1'b1;
                    addr_next   = addr_reg + 1'b1;
                end
                if (rvalid_reg && rdata.age == gen_reg)
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
                if (!rvalid_reg && 32'(addr_reg) >= 32'(slots_reg))
                begin
                    state_next = chtwa_pkg::ST_DIVIDE;
                    way_next   = '1;
                end
            end

            chtwa_pkg::ST_DIVIDE:
            begin
                div_start = way_reg != '0;
                way_next  = '0;
                if (div_done)
                begin
                    rsp_next.fullness_permille = 10'(div_q);
                    done_next  = 1'b1;
                    state_next = chtwa_pkg::ST_IDLE;
                end
            end

            chtwa_pkg::ST_DONE:
            begin
                if ((req_reg.action == chtwa_pkg::ACT_PROBE ||
                     req_reg.action == chtwa_pkg::ACT_REFRESH) && found_reg)
                begin
                    rsp_next.hit                = 1'b1;
                    rsp_next.found_value        = fent_reg.score;
                    rsp_next.found_type         = fent_reg.etype;
                    rsp_next.found_depth        = fent_reg.depth;
                    rsp_next.found_move         = fent_reg.move;
                    rsp_next.found_static_value = fent_reg.stat;
                    if (req_reg.action == chtwa_pkg::ACT_REFRESH)
                    begin
                        we        = 1'b1;
                        waddr     = base_reg + AW'(fway_reg);
                        wdata     = fent_reg;
                        wdata.age = gen_reg;
                    end
                end
                done_next  = 1'b1;
                state_next = chtwa_pkg::ST_IDLE;
            end

            default:
            begin
                state_next = chtwa_pkg::ST_IDLE;
            end
        endcase
    end

    // control registers; reset starts a clearing pass
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= chtwa_pkg::ST_CLEAR;
            addr_reg   <= '0;
            req_reg    <= '0;
            gen_reg    <= '0;
            cc_reg     <= chtwa_pkg::CFG_W'(4096);
            done_reg   <= 1'b0;
            rvalid_reg <= 1'b0;
            way_reg    <= '0;
            found_reg  <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            addr_reg   <= addr_next;
            req_reg    <= req_next;
            gen_reg    <= gen_next;
            done_reg   <= done_next;
            rvalid_reg <= rvalid_next;
            way_reg    <= way_next;
            found_reg  <= found_next;
            if (cfg_we)
            begin
                cc_reg <= cfg_wdata;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        base_reg  <= base_next;
        rway_reg  <= rway_next;
        fway_reg  <= fway_next;
        fent_reg  <= fent_next;
        cway_reg  <= cway_next;
        cent_reg  <= cent_next;
        cnt_reg   <= cnt_next;
        slots_reg <= slots_next;
        rsp_reg   <= rsp_next;
    end

    assign done = done_reg;
    assign rsp  = rsp_reg;

    // a result strobe only follows a busy cycle
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy)) else $error("strobe without work");
    // a result is never shown while an item is in flight
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy) else $error("strobe while busy");
    // hit only reported for probe or refresh
    a_hit_action: assert property (@(posedge clk) disable iff (!rst_n)
        (done && rsp.hit) |-> (req_reg.action == chtwa_pkg::ACT_PROBE ||
                               req_reg.action == chtwa_pkg::ACT_REFRESH))
        else $error("hit on wrong action");

endmodule
